/* src/word_interleave_to_planar_lines_top_assert.svh */
// Assertion macros for the planar line reorderer.
`ifndef WORD_INTERLEAVE_TO_PLANAR_LINES_TOP_ASSERT_SVH
`define WORD_INTERLEAVE_TO_PLANAR_LINES_TOP_ASSERT_SVH

// Same-cycle implication.
`define WILP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WILP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/wilp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package wilp_pkg;

    localparam int ROW_BYTES  = 2048;
    localparam int MAX_PLANES = 8;
    localparam int PLANE_CAP  = ((ROW_BYTES / MAX_PLANES) / 2) * 2;

    localparam int BANK_W  = $clog2(ROW_BYTES);
    localparam int ADDR_W  = BANK_W + 1;
    localparam int LEN_W   = BANK_W + 1;
    localparam int K_W     = $clog2(MAX_PLANES);
    localparam int H_W     = BANK_W - 1;

    localparam int BPP_W   = 9;
    localparam int PC_W    = 4;
    localparam int PAD_W   = 10;
    localparam int RT_W    = 13;
    localparam int CFG_W   = 13;
    localparam int CIDX_W  = 2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    localparam logic [CIDX_W-1:0] REG_BPP = 2'd0;
    localparam logic [CIDX_W-1:0] REG_PC  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_PAD = 2'd2;
    localparam logic [CIDX_W-1:0] REG_RT  = 2'd3;

    typedef struct packed {
        logic [1:0] status;
        logic       row_end;
        logic       pic_end;
        logic       from_mem;
    } result_ctl_t;

    function automatic logic [BPP_W-1:0] eff_bytes(input logic [BPP_W-1:0] bpp);
        logic [BPP_W-1:0] b;
        b = {bpp[BPP_W-1:1], 1'b0};
        if (b > BPP_W'(PLANE_CAP)) b = BPP_W'(PLANE_CAP);
        if (b == '0) b = BPP_W'(2);
        return b;
    endfunction

    function automatic logic [PC_W-1:0] eff_planes(input logic [PC_W-1:0] pc);
        logic [PC_W-1:0] p;
        p = pc;
        if (p == '0) p = PC_W'(1);
        if (p > PC_W'(MAX_PLANES)) p = PC_W'(MAX_PLANES);
        return p;
    endfunction

endpackage

`default_nettype wire

/* src/wilp_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module wilp_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* src/word_interleave_to_planar_lines_top.sv */
// Interleaved-bitplane to planar row reorderer. Each transaction on the s_ channel is
// either a source byte push (s_cmd = 0) or a result pull (s_cmd = 1); a pull and a
// refused push each return one transaction on the m_ channel, registered in the staging slot
// and then in the output register. The block takes one transaction per cycle while m_ready
// keeps up and no counter rebuild is running; the output register plus one staging slot behind
// the row memory absorb a stall. Rows are held in a single 2 x 2048-byte memory (one write port
// for pushes, one registered read port for pulls), used as two ping-pong banks, with no clearing
// pass after reset. After every configuration write s_ready stays low while a bit-serial divider
// rebuilds the push address counters from the current row offset.
`timescale 1ns / 1ps
`default_nettype none
`include "word_interleave_to_planar_lines_top_assert.svh"

module word_interleave_to_planar_lines_top
    import wilp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              cfg_we,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,

    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_cmd,
    input  wire logic [7:0]        s_source_byte,

    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [7:0]             m_out_byte,
    output logic [1:0]             m_status,
    output logic                   m_row_end,
    output logic                   m_picture_end
);

    localparam logic [3:0] RC_LOAD = 4'(H_W + 1);

    // configuration
    logic [BPP_W-1:0] bpp_reg;
    logic [PC_W-1:0]  pc_reg;
    logic [PAD_W-1:0] pad_reg;
    logic [RT_W-1:0]  rt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg <= BPP_W'(40);
            pc_reg  <= PC_W'(4);
            pad_reg <= '0;
            rt_reg  <= RT_W'(200);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_BPP: bpp_reg <= cfg_data[BPP_W-1:0];
                REG_PC:  pc_reg  <= cfg_data[PC_W-1:0];
                REG_PAD: pad_reg <= cfg_data[PAD_W-1:0];
                REG_RT:  rt_reg  <= cfg_data[RT_W-1:0];
                default: ;
            endcase
        end
    end

    logic [BPP_W-1:0] be;
    logic [PC_W-1:0]  pe;
    logic [12:0]      len_full;
    logic [LEN_W-1:0] len;

    assign be       = eff_bytes(bpp_reg);
    assign pe       = eff_planes(pc_reg);
    assign len_full = 13'(be) * 13'(pe);
    assign len      = len_full[LEN_W-1:0];

    // state
    logic [BANK_W-1:0] push_off_reg,  push_off_next;
    logic              push_bank_reg, push_bank_next;
    logic              in_pad_reg,    in_pad_next;
    logic [PAD_W-1:0]  pad_cnt_reg,   pad_cnt_next;
    logic              half_reg,      half_next;
    logic [K_W-1:0]    k_reg,         k_next;
    logic [BANK_W-1:0] twog_reg,      twog_next;
    logic [BANK_W-1:0] pbase_reg,     pbase_next;
    logic [BANK_W-1:0] pull_off_reg,  pull_off_next;
    logic              pull_bank_reg, pull_bank_next;
    logic [1:0]        bank_full_reg, bank_full_next;
    logic [RT_W-1:0]   pulled_reg,    pulled_next;
    logic [3:0]        rc_cnt_reg,    rc_cnt_next;
    logic [H_W-1:0]    div_quo_reg,   div_quo_next;
    logic [PC_W-1:0]   div_rem_reg,   div_rem_next;

    logic              p1_valid_reg,  p1_valid_next;
    result_ctl_t       p1_reg,        p1_next;
    logic              m_valid_reg,   m_valid_next;
    result_ctl_t       m_ctl_reg,     m_ctl_next;
    logic [7:0]        m_byte_reg,    m_byte_next;

    logic              accept;
    logic              out_take;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;

    logic              res_valid;
    result_ctl_t       res_ctl;
    logic              finish;
    logic [LEN_W-1:0]  dest;
    logic [LEN_W-1:0]  off_inc;
    logic [LEN_W-1:0]  pull_inc;
    logic [PAD_W:0]    pad_inc;
    logic [RT_W:0]     rows_inc;
    logic [K_W:0]      k_inc;
    logic [PC_W-1:0]   rem_shift;
    logic [12:0]       pb_full;

    assign out_take = !m_valid_reg || m_ready;
    assign s_ready  = (rc_cnt_reg == '0) && !cfg_we && (!p1_valid_reg || out_take);
    assign accept   = s_valid && s_ready;

    assign dest     = LEN_W'(pbase_reg) + LEN_W'(twog_reg) + LEN_W'(half_reg);
    assign off_inc  = LEN_W'(push_off_reg) + LEN_W'(1);
    assign pull_inc = LEN_W'(pull_off_reg) + LEN_W'(1);
    assign pad_inc  = (PAD_W+1)'(pad_cnt_reg) + (PAD_W+1)'(1);
    assign rows_inc = (RT_W+1)'(pulled_reg) + (RT_W+1)'(1);
    assign k_inc    = (K_W+1)'(k_reg) + (K_W+1)'(1);

    assign rem_shift = {div_rem_reg[PC_W-2:0], div_quo_reg[H_W-1]};
    assign pb_full   = 13'(div_rem_reg) * 13'(be);

    always_comb begin
        push_off_next  = push_off_reg;
        push_bank_next = push_bank_reg;
        in_pad_next    = in_pad_reg;
        pad_cnt_next   = pad_cnt_reg;
        half_next      = half_reg;
        k_next         = k_reg;
        twog_next      = twog_reg;
        pbase_next     = pbase_reg;
        pull_off_next  = pull_off_reg;
        pull_bank_next = pull_bank_reg;
        bank_full_next = bank_full_reg;
        pulled_next    = pulled_reg;
        rc_cnt_next    = rc_cnt_reg;
        div_quo_next   = div_quo_reg;
        div_rem_next   = div_rem_reg;

        mem_we    = 1'b0;
        mem_waddr = {push_bank_reg, dest[BANK_W-1:0]};
        mem_re    = 1'b0;
        mem_raddr = {pull_bank_reg, pull_off_reg};

        res_valid = 1'b0;
        res_ctl   = '0;
        finish    = 1'b0;

        if (accept) begin
            if (s_cmd == CMD_PUSH) begin
                if (in_pad_reg) begin
                    pad_cnt_next = pad_inc[PAD_W-1:0];
                    if (pad_inc >= (PAD_W+1)'(pad_reg)) finish = 1'b1;
                end else if (bank_full_reg[push_bank_reg]) begin
                    res_valid      = 1'b1;
                    res_ctl.status = ST_FULL;
                end else begin
                    mem_we = !dest[LEN_W-1];
                    if (off_inc >= len) begin
                        bank_full_next[push_bank_reg] = 1'b1;
                        push_off_next = '0;
                        half_next     = 1'b0;
                        k_next        = '0;
                        twog_next     = '0;
                        pbase_next    = '0;
                        if (pad_reg == '0) begin
                            finish = 1'b1;
                        end else begin
                            in_pad_next  = 1'b1;
                            pad_cnt_next = '0;
                        end
                    end else begin
                        push_off_next = off_inc[BANK_W-1:0];
                        if (!half_reg) begin
                            half_next = 1'b1;
                        end else begin
                            half_next = 1'b0;
                            if (PC_W'(k_inc) >= pe) begin
                                k_next     = '0;
                                pbase_next = '0;
                                twog_next  = twog_reg + BANK_W'(2);
                            end else begin
                                k_next     = k_inc[K_W-1:0];
                                pbase_next = pbase_reg + BANK_W'(be);
                            end
                        end
                    end
                end
            end else begin
                res_valid = 1'b1;
                if (!bank_full_reg[pull_bank_reg]) begin
                    res_ctl.status = ST_EMPTY;
                end else begin
                    mem_re           = 1'b1;
                    res_ctl.status   = ST_OK;
                    res_ctl.from_mem = 1'b1;
                    if (pull_inc >= len) begin
                        res_ctl.row_end = 1'b1;
                        if (rows_inc >= (RT_W+1)'(rt_reg)) begin
                            res_ctl.pic_end = 1'b1;
                            pulled_next     = '0;
                        end else begin
                            pulled_next = rows_inc[RT_W-1:0];
                        end
                        bank_full_next[pull_bank_reg] = 1'b0;
                        pull_bank_next = !pull_bank_reg;
                        pull_off_next  = '0;
                    end else begin
                        pull_off_next = pull_inc[BANK_W-1:0];
                    end
                end
            end
        end

        if (finish) begin
            push_off_next  = '0;
            half_next      = 1'b0;
            k_next         = '0;
            twog_next      = '0;
            pbase_next     = '0;
            in_pad_next    = 1'b0;
            pad_cnt_next   = '0;
            push_bank_next = !push_bank_reg;
        end

        // rebuild plane / group counters from the row offset after any configuration write
        if (cfg_we) begin
            rc_cnt_next  = RC_LOAD;
            div_quo_next = push_off_reg[BANK_W-1:1];
            div_rem_next = '0;
        end else if (rc_cnt_reg > 4'd1) begin
            rc_cnt_next = rc_cnt_reg - 4'd1;
            if (rem_shift >= pe) begin
                div_rem_next = rem_shift - pe;
                div_quo_next = {div_quo_reg[H_W-2:0], 1'b1};
            end else begin
                div_rem_next = rem_shift;
                div_quo_next = {div_quo_reg[H_W-2:0], 1'b0};
            end
        end else if (rc_cnt_reg == 4'd1) begin
            rc_cnt_next = '0;
            k_next      = div_rem_reg[K_W-1:0];
            twog_next   = {div_quo_reg, 1'b0};
            half_next   = push_off_reg[0];
            pbase_next  = pb_full[BANK_W-1:0];
        end
    end

    always_comb begin
        p1_valid_next = p1_valid_reg;
        p1_next       = p1_reg;
        m_valid_next  = m_valid_reg;
        m_ctl_next    = m_ctl_reg;
        m_byte_next   = m_byte_reg;

        if (out_take) begin
            m_valid_next = p1_valid_reg;
            if (p1_valid_reg) begin
                m_ctl_next  = p1_reg;
                m_byte_next = p1_reg.from_mem ? mem_rdata : 8'd0;
            end
        end

        if (accept) begin
            p1_valid_next = res_valid;
            p1_next       = res_ctl;
        end else if (out_take) begin
            p1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            push_off_reg  <= '0;
            push_bank_reg <= 1'b0;
            in_pad_reg    <= 1'b0;
            pad_cnt_reg   <= '0;
            half_reg      <= 1'b0;
            k_reg         <= '0;
            twog_reg      <= '0;
            pbase_reg     <= '0;
            pull_off_reg  <= '0;
            pull_bank_reg <= 1'b0;
            bank_full_reg <= '0;
            pulled_reg    <= '0;
            rc_cnt_reg    <= '0;
            p1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            push_off_reg  <= push_off_next;
            push_bank_reg <= push_bank_next;
            in_pad_reg    <= in_pad_next;
            pad_cnt_reg   <= pad_cnt_next;
            half_reg      <= half_next;
            k_reg         <= k_next;
            twog_reg      <= twog_next;
            pbase_reg     <= pbase_next;
            pull_off_reg  <= pull_off_next;
            pull_bank_reg <= pull_bank_next;
            bank_full_reg <= bank_full_next;
            pulled_reg    <= pulled_next;
            rc_cnt_reg    <= rc_cnt_next;
            p1_valid_reg  <= p1_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        div_quo_reg <= div_quo_next;
        div_rem_reg <= div_rem_next;
        p1_reg      <= p1_next;
        m_ctl_reg   <= m_ctl_next;
        m_byte_reg  <= m_byte_next;
    end

    wilp_ram #(
        .ADDR_W(ADDR_W),
        .DATA_W(8)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (s_source_byte),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_byte_reg;
    assign m_status      = m_ctl_reg.status;
    assign m_row_end     = m_ctl_reg.row_end;
    assign m_picture_end = m_ctl_reg.pic_end;

    `WILP_ASSERT_NEXT(a_full_push_refused, accept && (s_cmd == CMD_PUSH) && !in_pad_reg && bank_full_reg[push_bank_reg], p1_valid_reg && (p1_reg.status == ST_FULL), "refused push lost its status")
    `WILP_ASSERT_NEXT(a_stage_holds, p1_valid_reg && !out_take, p1_valid_reg && $stable(p1_reg), "staged transaction dropped under stall")
    `WILP_ASSERT_IMPL(a_no_data_flags, m_valid && (m_status != ST_OK), !m_row_end && !m_picture_end && (m_out_byte == 8'd0), "flags set on a non-data result")

endmodule

`default_nettype wire
